@@ design/sks_pkg.sv @@
// Shared types, field widths and register codes of the scalar Kalman smoother.
package sks_pkg;

  localparam int unsigned CH_W       = 3;
  localparam int unsigned MEAS_W     = 24;
  localparam int unsigned EST_W      = 32;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned VAR_W      = 32;
  localparam int unsigned NOISE_W    = 16;
  localparam int unsigned START_E_W  = 24;
  localparam int unsigned START_V_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned Q_SHIFT    = 16;
  localparam int unsigned NOISE_REGS = 6;
  localparam int unsigned NOISE_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_CH5   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_EST   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_VAR   = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [NOISE_W-1:0]   NOISE_RST       = 16'd25;
  localparam logic [NOISE_W-1:0]   NOISE_CH5_RST   = 16'd125;
  localparam logic [START_E_W-1:0] START_EST_RST   = 24'd500;
  localparam logic [START_V_W-1:0] START_VAR_RST   = 16'd255;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_MULE = 7'b0001000,
    S_MULV = 7'b0010000,
    S_WB   = 7'b0100000,
    S_DONE = 7'b1000000
  } sks_state_e;

endpackage

@@ design/scalar_kalman_smoother.sv @@
// Top level of the multi-channel scalar Kalman smoother for inertial sensor samples.
//
// Usage: each input transfer on the s_axis channel carries one sample: the
// measurement in tdata and the channel number plus a restart flag in tuser.
// For every accepted sample exactly one result transfer leaves on m_axis with
// the channel in tuser and the updated estimate, the gain used and the
// updated variance in tdata. The block keeps an estimate and a variance per
// channel; a channel that was never loaded since reset, or whose sample has
// restart set, first reloads both from the start registers.
// Sequence: the block takes one sample at a time. A valid channel's input
// transfer also reads the channel store; its result then passes through one
// load step that starts the shared restoring divider, 17 divider steps and
// the divider's done flag, the shared multiplier (estimate, then variance),
// a write back and the hand-off to the output register. The next sample is
// taken once that hand-off is done and the sequencer is idle again.
// A channel number at or above CHANNELS yields an all-zero result with no
// update and no state change. s_axis_tready is high only while
// the sequencer waits for a sample. Reset clears the loaded flags of all
// channels and returns the configuration registers to their default values.
// A stalled result holds; the next sample may finish and wait behind it.
module scalar_kalman_smoother import sks_pkg::*; #(
  parameter int unsigned CHANNELS           = 6,
  parameter int unsigned ESTIMATE_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [23:0] measurement
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [2:0] channel, [3] restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] estimate, [48:32] gain,
                                                // [80:49] variance, rest zero
  output logic [OUT_USER_W-1:0] m_axis_tuser,   // [2:0] out_channel
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SMEAS_W = MEAS_W + ESTIMATE_FRAC_BITS;
  localparam int unsigned DIFF_W  = ((SMEAS_W > EST_W) ? SMEAS_W : EST_W) + 1;
  localparam int unsigned MULB_W  = GAIN_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + MULB_W;
  localparam int unsigned INC_W   = PROD_W - Q_SHIFT;
  localparam int unsigned SUM_W   = INC_W + 1;
  localparam logic [6:0]  CH_LIMIT = 7'(CHANNELS);

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic [EST_W-1:0] sat32(input logic [SUM_W-1:0] v);
    logic [EST_W-1:0] r;
    if ((&v[SUM_W-1:EST_W-1]) || !(|v[SUM_W-1:EST_W-1])) begin
      r = v[EST_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(EST_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [NOISE_W-1:0]   noise_q [NOISE_REGS];
  logic [START_E_W-1:0] start_est_q;
  logic [START_V_W-1:0] start_var_q;

  // Control state.
  sks_state_e           state_q, state_d;
  logic [CHANNELS-1:0]  loaded_q;
  logic                 out_valid_q;

  // Per-item working registers.
  logic [CH_W-1:0]      ch_q;
  logic [IDX_W-1:0]     idx_q;
  logic [MEAS_W-1:0]    meas_q;
  logic                 restart_q;
  logic [EST_W-1:0]     est_q;
  logic [VAR_W-1:0]     var_q;
  logic [GAIN_W-1:0]    gain_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [EST_W-1:0]     est_rd_q;
  logic [VAR_W-1:0]     var_rd_q;

  // Output register.
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  // Channel store, one entry per channel.
  logic [EST_W-1:0]     est_mem [CHANNELS];
  logic [VAR_W-1:0]     var_mem [CHANNELS];

  logic                 in_xfer;
  logic [CH_W-1:0]      in_ch;
  logic                 in_ch_ok;
  logic [IDX_W-1:0]     in_idx;
  logic                 reload;
  logic [EST_W-1:0]     est_load;
  logic [VAR_W-1:0]     var_load;
  logic [SUM_W-1:0]     start_wide;
  logic [NOISE_W-1:0]   noise_sel;
  logic signed [DIFF_W-1:0] meas_wide;
  logic signed [DIFF_W-1:0] est_wide;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic [INC_W-1:0]     inc;
  logic [SUM_W-1:0]     est_sum;
  logic [EST_W-1:0]     est_new;
  logic [VAR_W-1:0]     var_new;
  logic                 out_free;
  div_ctrl_t            div_ctrl;
  div_status_t          div_status;
  logic [GAIN_W-1:0]    div_gain;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_ch         = s_axis_tuser[CH_W-1:0];
  assign in_ch_ok      = ({4'b0000, in_ch} < CH_LIMIT);
  assign in_idx        = IDX_W'(in_ch);

  // Reload values: the start estimate scaled to the fraction format, saturated.
  assign start_wide = {{(SUM_W-START_E_W){start_est_q[START_E_W-1]}}, start_est_q}
                      << ESTIMATE_FRAC_BITS;
  assign est_load   = sat32(start_wide);
  assign var_load   = {start_var_q, 16'h0000};
  assign reload     = restart_q || !loaded_q[idx_q];

  // Channels beyond the noise registers share the last one.
  assign noise_sel = ({1'b0, ch_q} < 4'(NOISE_REGS))
                     ? noise_q[NOISE_IDX_W'(ch_q)] : noise_q[NOISE_REGS-1];

  assign div_ctrl.start = (state_q == S_LOAD) && !div_status.busy;

  sks_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .var_i    (reload ? var_load : var_rd_q),
    .noise_i  (noise_sel),
    .gain_o   (div_gain),
    .status_o (div_status)
  );

  // Shared multiplier: innovation times gain, then variance times (1 - gain).
  assign meas_wide = $signed({{(DIFF_W-MEAS_W){meas_q[MEAS_W-1]}}, meas_q})
                     <<< ESTIMATE_FRAC_BITS;
  assign est_wide  = $signed({{(DIFF_W-EST_W){est_q[EST_W-1]}}, est_q});
  assign diff      = meas_wide - est_wide;

  always_comb begin
    if (state_q == S_MULV) begin
      mul_a = $signed({{(DIFF_W-VAR_W){1'b0}}, var_q});
      mul_b = $signed({1'b0, ONE_Q16 - gain_q});
    end else begin
      mul_a = diff;
      mul_b = $signed({1'b0, gain_q});
    end
  end

  assign prod_d  = mul_a * mul_b;

  // The arithmetic shift by 16 is the floor of the division by 65536.
  assign inc     = prod_q[PROD_W-1:Q_SHIFT];
  assign est_sum = {{(SUM_W-EST_W){est_q[EST_W-1]}}, est_q} + {inc[INC_W-1], inc};
  assign est_new = sat32(est_sum);
  assign var_new = prod_q[VAR_W+Q_SHIFT-1:Q_SHIFT];

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = in_ch_ok ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_status.done) begin
          state_d = S_MULE;
        end
      end
      S_MULE: state_d = S_MULV;
      S_MULV: state_d = S_WB;
      S_WB:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NOISE_REGS - 1; i++) begin
        noise_q[i] <= NOISE_RST;
      end
      noise_q[REG_NOISE_CH5] <= NOISE_CH5_RST;
      start_est_q <= START_EST_RST;
      start_var_q <= START_VAR_RST;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD) begin
        loaded_q[idx_q] <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_EST: start_est_q <= cfg_data_i;
          REG_START_VAR: start_var_q <= cfg_data_i[START_V_W-1:0];
          default: noise_q[NOISE_IDX_W'(cfg_idx_i)] <= cfg_data_i[NOISE_W-1:0];
        endcase
      end
    end
  end

  // Datapath registers; a channel out of range leaves an all-zero result.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          ch_q      <= in_ch;
          idx_q     <= in_idx;
          meas_q    <= s_axis_tdata[MEAS_W-1:0];
          restart_q <= s_axis_tuser[CH_W];
          est_q     <= '0;
          var_q     <= '0;
          gain_q    <= '0;
        end
      end
      S_LOAD: begin
        est_q <= reload ? est_load : est_rd_q;
        var_q <= reload ? var_load : var_rd_q;
      end
      S_DIV: begin
        if (div_status.done) begin
          gain_q <= div_gain;
        end
      end
      S_MULV: est_q <= est_new;
      S_WB:   var_q <= var_new;
      S_DONE: begin
        if (out_free) begin
          out_data_q <= {7'b0000000, var_q, gain_q, est_q};
          out_user_q <= ch_q;
        end
      end
      default: ;
    endcase
  end

  // Channel store: registered read at the input transfer, write back after the update.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      est_rd_q <= est_mem[in_idx];
      var_rd_q <= var_mem[in_idx];
    end
    if (state_q == S_WB) begin
      est_mem[idx_q] <= est_q;
      var_mem[idx_q] <= var_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ design/sks_divider.sv @@
// Restoring divider that forms the unsigned Q1.16 gain var / (var + noise) one bit per cycle.
module sks_divider import sks_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctrl_t           ctrl_i,
  input  logic [VAR_W-1:0]    var_i,
  input  logic [NOISE_W-1:0]  noise_i,
  output logic [GAIN_W-1:0]   gain_o,
  output div_status_t         status_o
);

  localparam logic [4:0] LAST_BIT = 5'(GAIN_W - 1);

  logic [VAR_W:0]    den_q;
  logic [VAR_W:0]    rem_q;
  logic              lsb_q;
  logic [GAIN_W-1:0] quo_q;
  logic [4:0]        cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [VAR_W+1:0]  trial;
  logic [VAR_W+1:0]  diff;
  logic              take;

  // The dividend is var shifted up by 16; its low 17 bits are var[0] and zeros.
  assign trial = {rem_q, (cnt_q == LAST_BIT) ? lsb_q : 1'b0};
  assign diff  = trial - {1'b0, den_q};
  assign take  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= LAST_BIT;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      den_q <= {1'b0, var_i} + {1'b0, noise_i, 16'h0000};
      rem_q <= {2'b00, var_i[VAR_W-1:1]};
      lsb_q <= var_i[0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[VAR_W:0] : trial[VAR_W:0];
      quo_q <= {quo_q[GAIN_W-2:0], take};
    end
  end

  // A zero denominator means zero variance and zero noise: the gain is zero.
  assign gain_o          = (den_q == '0) ? '0 : quo_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

@@ design/sks_checker.sv @@
// Port-level checker for the scalar Kalman smoother and its bind statement.
module sks_checker import sks_pkg::*; #(
  parameter int unsigned CHANNELS = 6
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  // One sample at a time: the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready stayed high after a transfer");

  // A new result only appears after the sequencer was busy.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work on a sample");

  // The gain never exceeds one in unsigned Q1.16.
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[48:32] <= 17'h10000))
    else $error("gain above one");

  // A channel out of range gives an all-zero result.
  a_bad_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ({4'b0000, m_axis_tuser} >= CH_LIMIT)) |-> (m_axis_tdata == '0))
    else $error("nonzero result for a channel out of range");

  // A stalled result holds.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

endmodule

bind scalar_kalman_smoother sks_checker #(.CHANNELS(CHANNELS)) u_sks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
